### hdl/lpdc_pkg.sv
package lpdc_pkg;

   localparam logic [15:0] START_WORD   = 16'hFF5A;
   localparam logic [15:0] HEADER_BYTES = 16'd9;
   localparam logic [15:0] INDEX_MAX    = 16'hFFFF;

   // byte positions inside the header
   localparam logic [15:0] POS_START_HI = 16'd0;
   localparam logic [15:0] POS_START_LO = 16'd1;
   localparam logic [15:0] POS_LEN_HI   = 16'd2;
   localparam logic [15:0] POS_LEN_LO   = 16'd3;
   localparam logic [15:0] POS_CONTROL  = 16'd4;
   localparam logic [15:0] POS_SEQUENCE = 16'd5;
   localparam logic [15:0] POS_ACK      = 16'd6;
   localparam logic [15:0] POS_SESSION  = 16'd7;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_TOO_SHORT   = 3'd1,
      STATUS_BAD_START   = 3'd2,
      STATUS_HEADER_SUM  = 3'd3,
      STATUS_LEN_MISMATCH = 3'd4,
      STATUS_PAYLOAD_SUM = 3'd5
   } status_type;

   typedef struct packed {
      logic        end_of_packet;
      logic [7:0]  payload_data;
      status_type  status;
      logic [15:0] packet_length;
      logic [7:0]  control_bits;
      logic [7:0]  sequence_number;
      logic [7:0]  ack_number;
      logic [7:0]  session_number;
   } result_type;

endpackage

### hdl/link_packet_deframer_checksum_top.sv
// a result is registered in the output register before it shows on rsp_valid,
// and waits in the skid stage first while the output is held off
// throughput: one byte per cycle while ready is high; at most one payload byte
// or status per request; ready drops only while both output stages are full
// reset: synchronous active-high, clears the byte counter, sums and header fields
// and empties both output stages
module link_packet_deframer_checksum_top
   import lpdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_end_of_packet,
   output logic [7:0]  rsp_payload_data,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_packet_length,
   output logic [7:0]  rsp_control_bits,
   output logic [7:0]  rsp_sequence_number,
   output logic [7:0]  rsp_ack_number,
   output logic [7:0]  rsp_session_number
);

   logic       accept;
   logic       result_valid;
   result_type result;
   result_type out_data;

   assign accept = req_valid && req_ready;

   lpdc_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .final_byte   (req_final_byte),
      .result_valid (result_valid),
      .result       (result)
   );

   lpdc_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (result_valid),
      .push_data  (result),
      .can_accept (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_end_of_packet   = out_data.end_of_packet;
   assign rsp_payload_data    = out_data.payload_data;
   assign rsp_status          = out_data.status;
   assign rsp_packet_length   = out_data.packet_length;
   assign rsp_control_bits    = out_data.control_bits;
   assign rsp_sequence_number = out_data.sequence_number;
   assign rsp_ack_number      = out_data.ack_number;
   assign rsp_session_number  = out_data.session_number;

endmodule

### hdl/lpdc_parser.sv
module lpdc_parser
   import lpdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       final_byte,
   output logic       result_valid,
   output result_type result
);

   logic [15:0] byte_index_ff, byte_index_in;
   logic [7:0]  header_sum_ff, header_sum_in;
   logic [7:0]  payload_sum_ff, payload_sum_in;
   logic        start_ok_ff, start_ok_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  control_ff, control_in;
   logic [7:0]  sequence_ff, sequence_in;
   logic [7:0]  ack_ff, ack_in;
   logic [7:0]  session_ff, session_in;

   logic        in_header;
   logic        stream;
   logic [16:0] total;
   status_type  status;

   // header and payload updates for the byte at hand
   always_comb begin
      header_sum_in  = header_sum_ff;
      payload_sum_in = payload_sum_ff;
      start_ok_in    = start_ok_ff;
      length_in      = length_ff;
      control_in     = control_ff;
      sequence_in    = sequence_ff;
      ack_in         = ack_ff;
      session_in     = session_ff;
      in_header      = byte_index_ff < HEADER_BYTES;
      if (in_header) begin
         header_sum_in = header_sum_ff + data_byte;
         case (byte_index_ff)
            POS_START_HI: if (data_byte != START_WORD[15:8]) start_ok_in = 1'b0;
            POS_START_LO: if (data_byte != START_WORD[7:0]) start_ok_in = 1'b0;
            POS_LEN_HI:   length_in = {data_byte, length_ff[7:0]};
            POS_LEN_LO:   length_in = {length_ff[15:8], data_byte};
            POS_CONTROL:  control_in = data_byte;
            POS_SEQUENCE: sequence_in = data_byte;
            POS_ACK:      ack_in = data_byte;
            POS_SESSION:  session_in = data_byte;
            default: ;
         endcase
      end else begin
         payload_sum_in = payload_sum_ff + data_byte;
      end
   end

   // a saturated index gives a total no length field can reach
   assign total  = {1'b0, byte_index_ff} + 17'd1;
   assign stream = !in_header && (length_ff > HEADER_BYTES)
                   && (({1'b0, byte_index_ff} + 17'd2) <= {1'b0, length_ff});

   always_comb begin
      if (total < {1'b0, HEADER_BYTES})
         status = STATUS_TOO_SHORT;
      else if (!start_ok_in)
         status = STATUS_BAD_START;
      else if (header_sum_in != 8'd0)
         status = STATUS_HEADER_SUM;
      else if ({1'b0, length_in} != total)
         status = STATUS_LEN_MISMATCH;
      else if ((length_in > HEADER_BYTES) && (payload_sum_in != 8'd0))
         status = STATUS_PAYLOAD_SUM;
      else
         status = STATUS_OK;
   end

   always_comb begin
      result_valid = accept && (final_byte || stream);
      if (final_byte) begin
         result.end_of_packet   = 1'b1;
         result.payload_data    = 8'd0;
         result.status          = status;
         result.packet_length   = length_in;
         result.control_bits    = control_in;
         result.sequence_number = sequence_in;
         result.ack_number      = ack_in;
         result.session_number  = session_in;
      end else begin
         result.end_of_packet   = 1'b0;
         result.payload_data    = data_byte;
         result.status          = STATUS_OK;
         result.packet_length   = 16'd0;
         result.control_bits    = 8'd0;
         result.sequence_number = 8'd0;
         result.ack_number      = 8'd0;
         result.session_number  = 8'd0;
      end
   end

   assign byte_index_in = (byte_index_ff == INDEX_MAX) ? byte_index_ff
                          : byte_index_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset || (accept && final_byte)) begin
         byte_index_ff  <= '0;
         header_sum_ff  <= '0;
         payload_sum_ff <= '0;
         start_ok_ff    <= 1'b1;
         length_ff      <= '0;
         control_ff     <= '0;
         sequence_ff    <= '0;
         ack_ff         <= '0;
         session_ff     <= '0;
      end else if (accept) begin
         byte_index_ff  <= byte_index_in;
         header_sum_ff  <= header_sum_in;
         payload_sum_ff <= payload_sum_in;
         start_ok_ff    <= start_ok_in;
         length_ff      <= length_in;
         control_ff     <= control_in;
         sequence_ff    <= sequence_in;
         ack_ff         <= ack_in;
         session_ff     <= session_in;
      end
   end

endmodule

### hdl/lpdc_out_buf.sv
module lpdc_out_buf
   import lpdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       can_accept,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       out_valid_ff;
   result_type out_data_ff;
   logic       skid_valid_ff;
   result_type skid_data_ff;

   // skid stage catches a result arriving while the output is stalled
   assign can_accept = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && out_ready) begin
         if (skid_valid_ff) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else if (push) begin
            out_data_ff <= push_data;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff) begin
         if (push) begin
            out_valid_ff <= 1'b1;
            out_data_ff  <= push_data;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= push_data;
      end
   end

endmodule

### hdl/lpdc_checker.sv
module lpdc_checker
   import lpdc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_final_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_end_of_packet,
   input logic [7:0]  rsp_payload_data,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_packet_length,
   input logic [7:0]  rsp_control_bits,
   input logic [7:0]  rsp_sequence_number,
   input logic [7:0]  rsp_ack_number,
   input logic [7:0]  rsp_session_number
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // an accepted final byte is always followed by a valid result on the next cycle
   a_final_gives_status: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_final_byte |=> rsp_valid)
      else $error("no result after final byte");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_packet |-> rsp_status == STATUS_OK
         && rsp_packet_length == 16'd0 && rsp_session_number == 8'd0
         && rsp_control_bits == 8'd0 && rsp_sequence_number == 8'd0
         && rsp_ack_number == 8'd0)
      else $error("payload result carries header fields");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_packet |-> rsp_payload_data == 8'd0
         && rsp_status <= STATUS_PAYLOAD_SUM)
      else $error("status result malformed");

endmodule

bind link_packet_deframer_checksum_top lpdc_checker u_checker (.*);
